FILE: rtl/ppc_pkg.sv
`default_nettype none

package ppc_pkg;

    // Field widths
    localparam int CLK_W  = 30;
    localparam int DUTY_W = 17;
    localparam int OUT_W  = 16;

    // Serial multiplier: wide operand shifts left, narrow operand shifts right
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 31;
    localparam int CNT_W   = $clog2(MUL_B_W);

    localparam int PERIOD_BITS_DEF = 16;

    localparam logic [CLK_W-1:0]   CLK_RESET = CLK_W'(170000000);
    localparam logic [MUL_A_W-1:0] DUTY_HALF = MUL_A_W'(32'h8000);
    localparam logic [OUT_W-1:0]   CMP_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PRESC,
        ST_MUL_FP,
        ST_DIV_PERIOD,
        ST_MUL_COUNTS,
        ST_DIV_ACTUAL,
        ST_MUL_DUTY,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/pwm_prescaler_period_calc.sv
`default_nettype none

// PWM prescaler and period calculator. For each request (requested frequency,
// duty, direction, running flag) it finds the smallest prescaler that keeps the
// period within PERIOD_BITS bits, and returns prescaler-1, the period, the
// frequency actually reached and, when the timer runs, the rounded duty compare
// on channel B (forward) or A (backward). A frequency of zero or above the timer
// clock returns status 1 with all other fields zero. One request is handled at
// a time by a single bit-serial restoring divider, used three times, and a
// shift-add multiplier, used three times with the timer running and twice
// when stopped. The result sits in an output register, so a new request is
// taken while the previous result waits. timer_clock_hz is to be written
// through cfg_wr_en / cfg_wr_data only while the block is idle; the block
// itself does not enforce this.
module pwm_prescaler_period_calc #(
    parameter int PERIOD_BITS = ppc_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_wr_en,
    input  wire logic [ppc_pkg::CLK_W-1:0]   cfg_wr_data,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ppc_pkg::CLK_W-1:0]   requested_freq_hz,
    input  wire logic [ppc_pkg::DUTY_W-1:0]  duty_fraction,
    input  wire logic                        forward,
    input  wire logic                        running,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ppc_pkg::OUT_W-1:0]        prescaler_minus_one,
    output logic [ppc_pkg::OUT_W-1:0]        period_count,
    output logic [ppc_pkg::CLK_W-1:0]        actual_freq_hz,
    output logic [ppc_pkg::OUT_W-1:0]        compare_a,
    output logic [ppc_pkg::OUT_W-1:0]        compare_b,
    output logic                             compares_loaded,
    output logic                             status
);

    localparam int CLK_W   = ppc_pkg::CLK_W;
    localparam int DUTY_W  = ppc_pkg::DUTY_W;
    localparam int OUT_W   = ppc_pkg::OUT_W;
    localparam int MUL_A_W = ppc_pkg::MUL_A_W;
    localparam int MUL_B_W = ppc_pkg::MUL_B_W;
    localparam int CNT_W   = ppc_pkg::CNT_W;
    // divisor holds f*(2^PERIOD_BITS+1) on the first pass
    localparam int DIV_W   = CLK_W + PERIOD_BITS + 1;

    ppc_pkg::state_t state_reg, state_next;

    logic [CLK_W-1:0]   clk_hz_reg;
    logic [CLK_W-1:0]   freq_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               fwd_reg;
    logic               run_reg;
    logic               bad_reg;
    logic [CLK_W-1:0]   presc_reg;
    logic [CLK_W-1:0]   counts_reg;
    logic [CLK_W-1:0]   actual_reg;
    logic [OUT_W-1:0]   cmp_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [CLK_W-1:0]   div_rem_reg;
    logic [CLK_W-1:0]   div_quo_reg;
    logic [DIV_W-1:0]   div_den_reg;
    logic [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic [MUL_A_W-1:0] mul_acc_reg;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   presc_out_reg;
    logic [OUT_W-1:0]   period_out_reg;
    logic [CLK_W-1:0]   actual_out_reg;
    logic [OUT_W-1:0]   cmp_a_out_reg;
    logic [OUT_W-1:0]   cmp_b_out_reg;
    logic               loaded_out_reg;
    logic               status_out_reg;

    logic               in_fire;
    logic               in_bad;
    logic               div_last;
    logic               mul_last;
    logic               out_free;
    logic [CLK_W:0]     div_trial;
    logic [CLK_W:0]     div_diff;
    logic               div_ge;
    logic [CLK_W-1:0]   div_rem_step;
    logic [CLK_W-1:0]   div_quo_step;
    logic [MUL_A_W-1:0] mul_acc_step;
    logic [CLK_W-1:0]   presc_m1;
    logic [CLK_W-1:0]   period_val;

    assign in_ready = (state_reg == ppc_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_bad   = (requested_freq_hz == '0) || (requested_freq_hz > clk_hz_reg);
    assign out_free = !out_valid_reg || out_ready;

    // Restoring divider step: one quotient bit per cycle
    assign div_trial    = {div_rem_reg, div_quo_reg[CLK_W-1]};
    assign div_ge       = DIV_W'(div_trial) >= div_den_reg;
    assign div_diff     = div_trial - div_den_reg[CLK_W:0];
    assign div_rem_step = div_ge ? div_diff[CLK_W-1:0] : div_trial[CLK_W-1:0];
    assign div_quo_step = {div_quo_reg[CLK_W-2:0], div_ge};
    assign div_last     = (cnt_reg == CNT_W'(CLK_W - 1));

    // Shift-add multiplier step: one multiplier bit per cycle
    assign mul_acc_step = mul_b_reg[0] ? (mul_acc_reg + mul_a_reg) : mul_acc_reg;
    assign mul_last     = (cnt_reg == CNT_W'(MUL_B_W - 1));

    assign presc_m1   = presc_reg - CLK_W'(1);
    assign period_val = counts_reg - CLK_W'(1);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ppc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppc_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = in_bad ? ppc_pkg::ST_FINISH : ppc_pkg::ST_DIV_PRESC;
            end
            ppc_pkg::ST_DIV_PRESC:
                if (div_last) state_next = ppc_pkg::ST_MUL_FP;
            ppc_pkg::ST_MUL_FP:
                if (mul_last) state_next = ppc_pkg::ST_DIV_PERIOD;
            ppc_pkg::ST_DIV_PERIOD:
                if (div_last) state_next = ppc_pkg::ST_MUL_COUNTS;
            ppc_pkg::ST_MUL_COUNTS:
                if (mul_last) state_next = ppc_pkg::ST_DIV_ACTUAL;
            ppc_pkg::ST_DIV_ACTUAL:
            begin
                if (div_last)
                    state_next = run_reg ? ppc_pkg::ST_MUL_DUTY : ppc_pkg::ST_FINISH;
            end
            ppc_pkg::ST_MUL_DUTY:
                if (mul_last) state_next = ppc_pkg::ST_FINISH;
            ppc_pkg::ST_FINISH:
                if (out_free) state_next = ppc_pkg::ST_IDLE;
            default:
                state_next = ppc_pkg::ST_IDLE;
        endcase
    end

    // Timer clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clk_hz_reg <= ppc_pkg::CLK_RESET;
        else if (cfg_wr_en)
            clk_hz_reg <= cfg_wr_data;
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (state_next != state_reg)
            cnt_reg <= '0;
        else if (state_reg != ppc_pkg::ST_IDLE && state_reg != ppc_pkg::ST_FINISH)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    // Datapath: divider, multiplier and intermediate results
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            ppc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    freq_reg    <= requested_freq_hz;
                    duty_reg    <= duty_fraction;
                    fwd_reg     <= forward;
                    run_reg     <= running;
                    bad_reg     <= in_bad;
                    div_rem_reg <= '0;
                    div_quo_reg <= clk_hz_reg;
                    div_den_reg <= (DIV_W'(requested_freq_hz) << PERIOD_BITS)
                                   + DIV_W'(requested_freq_hz);
                end
            end
            ppc_pkg::ST_DIV_PRESC:
            begin
                div_rem_reg <= div_rem_step;
                div_quo_reg <= div_quo_step;
                if (div_last)
                begin
                    // smallest prescaler = quotient + 1; next product f*p
                    presc_reg   <= div_quo_step + CLK_W'(1);
                    mul_a_reg   <= MUL_A_W'(freq_reg);
                    mul_b_reg   <= MUL_B_W'(div_quo_step + CLK_W'(1));
                    mul_acc_reg <= '0;
                end
            end
            ppc_pkg::ST_MUL_FP, ppc_pkg::ST_MUL_COUNTS:
            begin
                mul_acc_reg <= mul_acc_step;
                mul_a_reg   <= mul_a_reg << 1;
                mul_b_reg   <= mul_b_reg >> 1;
                if (mul_last)
                begin
                    div_rem_reg <= '0;
                    div_quo_reg <= clk_hz_reg;
                    div_den_reg <= DIV_W'(mul_acc_step);
                end
            end
            ppc_pkg::ST_DIV_PERIOD:
            begin
                div_rem_reg <= div_rem_step;
                div_quo_reg <= div_quo_step;
                if (div_last)
                begin
                    // timer counts = period + 1; next product counts*p
                    counts_reg  <= div_quo_step;
                    mul_a_reg   <= MUL_A_W'(div_quo_step);
                    mul_b_reg   <= MUL_B_W'(presc_reg);
                    mul_acc_reg <= '0;
                end
            end
            ppc_pkg::ST_DIV_ACTUAL:
            begin
                div_rem_reg <= div_rem_step;
                div_quo_reg <= div_quo_step;
                if (div_last)
                begin
                    // duty product starts at one half for round-half-up
                    actual_reg  <= div_quo_step;
                    mul_a_reg   <= MUL_A_W'(duty_reg);
                    mul_b_reg   <= MUL_B_W'(counts_reg);
                    mul_acc_reg <= ppc_pkg::DUTY_HALF;
                    cmp_reg     <= '0;
                end
            end
            ppc_pkg::ST_MUL_DUTY:
            begin
                mul_acc_reg <= mul_acc_step;
                mul_a_reg   <= mul_a_reg << 1;
                mul_b_reg   <= mul_b_reg >> 1;
                if (mul_last)
                begin
                    // saturate at full scale
                    if (mul_acc_step[MUL_A_W-1:32] != '0)
                        cmp_reg <= ppc_pkg::CMP_MAX;
                    else
                        cmp_reg <= mul_acc_step[31:16];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ppc_pkg::ST_FINISH && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ppc_pkg::ST_FINISH && out_free)
        begin
            if (bad_reg)
            begin
                presc_out_reg  <= '0;
                period_out_reg <= '0;
                actual_out_reg <= '0;
                cmp_a_out_reg  <= '0;
                cmp_b_out_reg  <= '0;
                loaded_out_reg <= 1'b0;
                status_out_reg <= 1'b1;
            end
            else
            begin
                presc_out_reg  <= presc_m1[OUT_W-1:0];
                period_out_reg <= period_val[OUT_W-1:0];
                actual_out_reg <= actual_reg;
                cmp_a_out_reg  <= (run_reg && !fwd_reg) ? cmp_reg : '0;
                cmp_b_out_reg  <= (run_reg && fwd_reg) ? cmp_reg : '0;
                loaded_out_reg <= run_reg;
                status_out_reg <= 1'b0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign prescaler_minus_one = presc_out_reg;
    assign period_count        = period_out_reg;
    assign actual_freq_hz      = actual_out_reg;
    assign compare_a           = cmp_a_out_reg;
    assign compare_b           = cmp_b_out_reg;
    assign compares_loaded     = loaded_out_reg;
    assign status              = status_out_reg;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;

    localparam int              CLK_W  = ppc_pkg::CLK_W;
    localparam int              DUTY_W = ppc_pkg::DUTY_W;
    localparam int              OUT_W  = ppc_pkg::OUT_W;
    localparam longint unsigned PERIOD_SPAN = 64'd1 << ppc_pkg::PERIOD_BITS_DEF;
    localparam longint unsigned CLK_MAX_HZ  = 64'd1000000000;
    localparam int              DRAIN_CYCLES = 200;
    localparam int              MAX_PRINTS   = 30;

    // One request: requested frequency, duty, direction and running flag
    typedef struct packed {
        logic [CLK_W-1:0]  freq;
        logic [DUTY_W-1:0] duty;
        logic              fwd;
        logic              run;
    } pwm_request_t;

    // One timer setting as the block reports it
    typedef struct packed {
        logic [OUT_W-1:0] presc_m1;
        logic [OUT_W-1:0] period;
        logic [CLK_W-1:0] actual;
        logic [OUT_W-1:0] cmp_a;
        logic [OUT_W-1:0] cmp_b;
        logic             loaded;
        logic             status;
    } pwm_setting_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CLK_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CLK_W-1:0]  requested_freq_hz = '0;
    logic [DUTY_W-1:0] duty_fraction = '0;
    logic              forward = 1'b0;
    logic              running = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [OUT_W-1:0]  prescaler_minus_one;
    logic [OUT_W-1:0]  period_count;
    logic [CLK_W-1:0]  actual_freq_hz;
    logic [OUT_W-1:0]  compare_a;
    logic [OUT_W-1:0]  compare_b;
    logic              compares_loaded;
    logic              status;

    pwm_request_t pending_requests[$];
    pwm_setting_t expected_settings[$];
    pwm_request_t next_req;
    pwm_setting_t got_setting;
    pwm_setting_t want_setting;
    logic [CLK_W-1:0] timer_clock_now = ppc_pkg::CLK_RESET;
    bit req_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_errors = 0;
    int n_requests = 0;
    int n_checked = 0;
    int n_rejected = 0;
    int n_full_scale = 0;
    int n_clock_settings = 1;

    pwm_prescaler_period_calc DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .requested_freq_hz   (requested_freq_hz),
        .duty_fraction       (duty_fraction),
        .forward             (forward),
        .running             (running),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .prescaler_minus_one (prescaler_minus_one),
        .period_count        (period_count),
        .actual_freq_hz      (actual_freq_hz),
        .compare_a           (compare_a),
        .compare_b           (compare_b),
        .compares_loaded     (compares_loaded),
        .status              (status)
    );

    // Expected timer setting for a request at a given timer clock
    function automatic pwm_setting_t calc_pwm_setting(pwm_request_t r, logic [CLK_W-1:0] tclk);
        pwm_setting_t s;
        longint unsigned f;
        longint unsigned c;
        longint unsigned presc;
        longint unsigned per;
        longint unsigned cmp;
        s = '0;
        f = 64'(r.freq);
        c = 64'(tclk);
        if (f == 0 || f > c)
        begin
            s.status = 1'b1;
            return s;
        end
        // smallest prescaler that keeps the period within range
        presc = c / ((PERIOD_SPAN + 1) * f) + 1;
        per = c / (f * presc) - 1;
        s.presc_m1 = OUT_W'(presc - 1);
        s.period = OUT_W'(per);
        s.actual = CLK_W'(c / ((per + 1) * presc));
        if (r.run)
        begin
            // round half up, clamp at full scale
            cmp = (64'(r.duty) * (per + 1) + 64'h8000) >> 16;
            if (cmp > 64'(ppc_pkg::CMP_MAX))
                cmp = 64'(ppc_pkg::CMP_MAX);
            if (r.fwd)
                s.cmp_b = OUT_W'(cmp);
            else
                s.cmp_a = OUT_W'(cmp);
            s.loaded = 1'b1;
        end
        return s;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        if (n_errors < MAX_PRINTS)
            $display("MISMATCH %s: got %0d expected %0d (result %0d, t=%0t)",
                     field, got, want, n_checked, $time);
        n_errors++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver and result-side stalls, on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    requested_freq_hz <= next_req.freq;
                    duty_fraction <= next_req.duty;
                    forward <= next_req.fwd;
                    running <= next_req.run;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on request acceptance, check on result acceptance
    always @(posedge clk)
    begin
        req_taken = in_valid && in_ready;
        if (req_taken)
        begin
            want_setting = calc_pwm_setting({requested_freq_hz, duty_fraction, forward, running},
                                            timer_clock_now);
            expected_settings.push_back(want_setting);
            n_requests++;
        end
        if (out_valid && out_ready)
        begin
            got_setting = {prescaler_minus_one, period_count, actual_freq_hz,
                           compare_a, compare_b, compares_loaded, status};
            if (expected_settings.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want_setting = expected_settings.pop_front();
                if (got_setting.presc_m1 !== want_setting.presc_m1)
                    report_mismatch("prescaler_minus_one", got_setting.presc_m1,
                                    want_setting.presc_m1);
                if (got_setting.period !== want_setting.period)
                    report_mismatch("period_count", got_setting.period, want_setting.period);
                if (got_setting.actual !== want_setting.actual)
                    report_mismatch("actual_freq_hz", got_setting.actual, want_setting.actual);
                if (got_setting.cmp_a !== want_setting.cmp_a)
                    report_mismatch("compare_a", got_setting.cmp_a, want_setting.cmp_a);
                if (got_setting.cmp_b !== want_setting.cmp_b)
                    report_mismatch("compare_b", got_setting.cmp_b, want_setting.cmp_b);
                if (got_setting.loaded !== want_setting.loaded)
                    report_mismatch("compares_loaded", got_setting.loaded, want_setting.loaded);
                if (got_setting.status !== want_setting.status)
                    report_mismatch("status", got_setting.status, want_setting.status);
                if (want_setting.status)
                    n_rejected++;
                if (want_setting.cmp_a == ppc_pkg::CMP_MAX || want_setting.cmp_b == ppc_pkg::CMP_MAX)
                    n_full_scale++;
                n_checked++;
            end
        end
    end

    task automatic add_request(longint unsigned f, int unsigned duty, bit fwd, bit run);
        pwm_request_t r;
        r.freq = CLK_W'(f);
        r.duty = DUTY_W'(duty);
        r.fwd = fwd;
        r.run = run;
        pending_requests.push_back(r);
    endtask

    // Block until nothing is queued, in flight or outstanding
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_settings.size() != 0);
    endtask

    // Frequency mix: rejects, near the clock, prescaler boundaries, log-spread, raw bits
    function automatic longint unsigned pick_freq(longint unsigned c);
        int unsigned sel;
        int unsigned s;
        longint unsigned f;
        longint unsigned kmax;
        longint unsigned k;
        sel = $urandom_range(99);
        if (sel < 8)
            f = $urandom_range(1) ? 0 : c + 1;
        else if (sel < 20)
            f = $urandom & 32'h3FFF_FFFF;
        else if (sel < 45)
            f = c - $urandom_range(0, (c > 1000) ? 1000 : c - 1);
        else if (sel < 65 && c > PERIOD_SPAN)
        begin
            kmax = c / (PERIOD_SPAN + 1);
            k = $urandom_range(1, kmax);
            f = c / ((PERIOD_SPAN + 1) * k) + $urandom_range(0, 2) - 1;
        end
        else
        begin
            s = $urandom_range(0, CLK_W - 1);
            f = ($urandom & ((32'd1 << s) - 1)) | (32'd1 << s);
            if (f > c)
                f = f % c + 1;
        end
        return f;
    endfunction

    function automatic int unsigned pick_duty();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'h10000;
            2: return 32'h8000;
            3: return $urandom_range(0, 32'h1FFFF);
            default: return $urandom_range(0, 32'h10000);
        endcase
    endfunction

    // Random requests; under pressure the sender waits for a drained block now and then
    task automatic run_random(int count, bit pressure);
        for (int i = 0; i < count; i++)
        begin
            if (pressure && (i % 3) == 0)
                wait_idle();
            add_request(pick_freq(64'(timer_clock_now)), pick_duty(), 1'($urandom_range(1)),
                        $urandom_range(3) != 0);
        end
    endtask

    // Drain, let the block settle, then load a new timer clock
    task automatic new_phase(longint unsigned tclk, int s_idle, int r_idle);
        wait_idle();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CLK_W'(tclk);
        timer_clock_now = CLK_W'(tclk);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        n_clock_settings++;
    endtask

    // Stimulus
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed requests at the reset clock
        send_idle_pct = 24;
        recv_idle_pct = 81;
        add_request(0, 32'h8000, 1, 1);
        add_request(64'(ppc_pkg::CLK_RESET) + 1, 32'h8000, 0, 1);
        add_request(32'h3FFF_FFFF, 32'h1FFFF, 1, 1);
        add_request(64'(ppc_pkg::CLK_RESET), 32'h10000, 1, 1);
        add_request(64'(ppc_pkg::CLK_RESET), 32'h8000, 0, 1);
        add_request(64'(ppc_pkg::CLK_RESET), 32'h7FFF, 1, 1);
        add_request(1, 32'h10000, 0, 1);
        add_request(1, 0, 1, 1);
        add_request(2593, 32'h10000, 1, 1);
        add_request(2594, 32'h10000, 0, 1);
        add_request(2595, 32'h1FFFF, 1, 1);
        add_request(2594, 32'h1FFFF, 0, 1);
        add_request(1000, 32'h12345, 0, 1);
        add_request(50000, 32'h4000, 1, 0);
        add_request(50000, 32'h4000, 0, 0);
        add_request(50000, 32'h4000, 1, 1);
        add_request(50000, 32'h4000, 0, 1);
        add_request(20000, 32'h8000, 1, 1);
        add_request(32'h2000_0000, 32'h8000, 1, 1);
        add_request(32'h1555_5555, 32'h0AAAA, 0, 1);
        add_request(32'h0AAA_AAAA, 32'h15555, 1, 1);

        // sender light, receiver heavy
        new_phase(CLK_MAX_HZ, 24, 81);
        add_request(CLK_MAX_HZ, 32'h10000, 1, 1);
        add_request(1, 32'h10000, 0, 1);
        run_random(250, 0);

        // sender heavy, receiver light
        new_phase(1, 81, 24);
        add_request(1, 32'h10000, 1, 1);
        add_request(2, 32'h10000, 1, 1);
        run_random(100, 0);
        new_phase($urandom_range(1, CLK_MAX_HZ), 81, 24);
        run_random(250, 0);
        new_phase(64'd65536000, 81, 24);
        add_request(1000, 32'h10000, 1, 1);
        add_request(1000, 32'hFFFF, 0, 1);
        run_random(150, 0);

        // no idling
        new_phase($urandom_range(1, 200000), 0, 0);
        run_random(150, 0);
        new_phase(CLK_MAX_HZ, 0, 0);
        run_random(40, 1);
        new_phase($urandom_range(1, CLK_MAX_HZ), 0, 0);
        run_random(400, 0);
        new_phase(64'(ppc_pkg::CLK_RESET), 0, 0);
        run_random(350, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests over %0d timer clock settings, with idle and stall mixes",
                 n_requests, n_clock_settings);
        $display("Checked %0d results: %0d rejected, %0d full-scale compares, %0d mismatches",
                 n_checked, n_rejected, n_full_scale, n_errors);
        if (n_errors == 0 && expected_settings.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #25000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
